/* src/mnint_pkg.sv */
// ----------------------------------------------------------------------------
// mnint_pkg: shared types, codes and field helpers
// Arithmetic helpers for GF(2^61-1), command and status words between the
// controller and the datapath of the Newton interpolator.
// ----------------------------------------------------------------------------
package mnint_pkg;

  localparam int MOD_BITS       = 61;
  localparam int DEF_MAX_POINTS = 64;
  localparam int IDX_W          = 6;
  localparam int ST_W           = 2;

  typedef logic [MOD_BITS-1:0] field_t;

  localparam field_t FIELD_P = {MOD_BITS{1'b1}};
  // fermat exponent p-2
  localparam field_t INV_EXP = FIELD_P - field_t'(2);

  // result status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO = 2'd3;

  // multiplier operand selects
  localparam logic [2:0] MS_ACC_A  = 3'd0;
  localparam logic [2:0] MS_T2_A   = 3'd1;
  localparam logic [2:0] MS_R_B    = 3'd2;
  localparam logic [2:0] MS_B_B    = 3'd3;
  localparam logic [2:0] MS_R_T2   = 3'd4;
  localparam logic [2:0] MS_PD_ACC = 3'd5;
  localparam logic [2:0] MS_PD_N   = 3'd6;

  // datapath register and store updates
  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_INIT       = 4'd1;
  localparam logic [3:0] OP_ACC_HORNER = 4'd2;
  localparam logic [3:0] OP_T2_HORNER  = 4'd3;
  localparam logic [3:0] OP_INV_INIT   = 4'd4;
  localparam logic [3:0] OP_R_M        = 4'd5;
  localparam logic [3:0] OP_B_M        = 4'd6;
  localparam logic [3:0] OP_DIFF       = 4'd7;
  localparam logic [3:0] OP_ACC_M      = 4'd8;
  localparam logic [3:0] OP_C_UPD      = 4'd9;
  localparam logic [3:0] OP_C_ACC      = 4'd10;
  localparam logic [3:0] OP_P_N0       = 4'd11;
  localparam logic [3:0] OP_P_N        = 4'd12;
  localparam logic [3:0] OP_P_MADD     = 4'd13;
  localparam logic [3:0] OP_P_M        = 4'd14;

  typedef struct packed {
    logic             load;
    logic             mul_start;
    logic [2:0]       mul_sel;
    logic [3:0]       op;
    logic             out_load;
    logic             out_use_coef;
    logic [IDX_W-1:0] out_index;
    logic             out_last;
    logic [ST_W-1:0]  out_status;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic acc_zero;
    logic cd_zero;
    logic out_free;
  } sts_t;

  // all ones stands for zero
  function automatic field_t in_fold(field_t v);
    return (v == FIELD_P) ? '0 : v;
  endfunction

  function automatic field_t fadd(field_t a, field_t b);
    logic [MOD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, FIELD_P}) s = s - {1'b0, FIELD_P};
    return s[MOD_BITS-1:0];
  endfunction

  function automatic field_t fsub(field_t a, field_t b);
    logic [MOD_BITS:0] s;
    s = {1'b0, a} + {1'b0, FIELD_P} - {1'b0, b};
    if (s >= {1'b0, FIELD_P}) s = s - {1'b0, FIELD_P};
    return s[MOD_BITS-1:0];
  endfunction

  function automatic field_t fneg(field_t a);
    return (a == '0) ? '0 : (FIELD_P - a);
  endfunction

endpackage

/* src/mnint_mul.sv */
// ----------------------------------------------------------------------------
// mnint_mul: multi-cycle modular multiplier
// One 32x32 multiplier walks the four partial products, a 122-bit
// accumulator collects them, and s_r then res fold the product mod 2^61-1.
// ----------------------------------------------------------------------------
module mnint_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mnint_pkg::field_t op_a,
  input  mnint_pkg::field_t op_b,
  output logic              busy,
  output logic              done,
  output mnint_pkg::field_t res
);
  import mnint_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  field_t            a_r, b_r;
  logic [63:0]       pp_r;
  logic [121:0]      acc_r;
  logic [MOD_BITS:0] s_r;
  field_t            res_r;
  logic [31:0]       ma, mb;
  logic [63:0]       pp_nxt;
  logic [121:0]      addend;
  logic [MOD_BITS:0] t;

  // partial product select
  always_comb begin
    unique case (cnt_r)
      3'd0:    begin ma = a_r[31:0];                 mb = b_r[31:0]; end
      3'd1:    begin ma = a_r[31:0];                 mb = {3'b0, b_r[60:32]}; end
      3'd2:    begin ma = {3'b0, a_r[60:32]};        mb = b_r[31:0]; end
      default: begin ma = {3'b0, a_r[60:32]};        mb = {3'b0, b_r[60:32]}; end
    endcase
    pp_nxt = ma * mb;
  end

  // shift of the partial product registered on the previous cycle
  always_comb begin
    unique case (cnt_r)
      3'd1:       addend = {58'b0, pp_r};
      3'd2, 3'd3: addend = {58'b0, pp_r} << 32;
      default:    addend = {58'b0, pp_r} << 64;
    endcase
  end

  // final fold
  always_comb begin
    t = {1'b0, s_r[MOD_BITS-1:0]} + {{MOD_BITS{1'b0}}, s_r[MOD_BITS]};
    if (t >= {1'b0, FIELD_P}) t = t - {1'b0, FIELD_P};
  end

  // sequencing
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd6) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // arithmetic pipeline
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r <= 3'd3) pp_r <= pp_nxt;
      if (cnt_r >= 3'd1 && cnt_r <= 3'd4) acc_r <= acc_r + addend;
      if (cnt_r == 3'd5) s_r <= {1'b0, acc_r[60:0]} + {1'b0, acc_r[121:61]};
      if (cnt_r == 3'd6) res_r <= t[MOD_BITS-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = res_r;

endmodule

/* src/mnint_ctrl.sv */
// ----------------------------------------------------------------------------
// mnint_ctrl: interpolation sequencer
// Walks the Horner evaluations, the Fermat inverse, the store updates and
// the trimmed emission of coefficients or of a status word, one step of the datapath at a time.
// ----------------------------------------------------------------------------
module mnint_ctrl #(
  parameter int MAX_POINTS = mnint_pkg::DEF_MAX_POINTS,
  parameter int CW         = 7,
  parameter int AW         = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_last_point,
  input  mnint_pkg::sts_t sts,
  output mnint_pkg::cmd_t cmd,
  output logic [AW-1:0]  raddr,
  output logic [AW-1:0]  waddr
);
  import mnint_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_H1      = 5'd1;
  localparam logic [4:0] S_H1_W    = 5'd2;
  localparam logic [4:0] S_H2      = 5'd3;
  localparam logic [4:0] S_H2_W    = 5'd4;
  localparam logic [4:0] S_CHK     = 5'd5;
  localparam logic [4:0] S_INV     = 5'd6;
  localparam logic [4:0] S_INV_RW  = 5'd7;
  localparam logic [4:0] S_INV_B   = 5'd8;
  localparam logic [4:0] S_INV_BW  = 5'd9;
  localparam logic [4:0] S_DIFF    = 5'd10;
  localparam logic [4:0] S_T1      = 5'd11;
  localparam logic [4:0] S_T1_W    = 5'd12;
  localparam logic [4:0] S_CU      = 5'd13;
  localparam logic [4:0] S_CU_M    = 5'd14;
  localparam logic [4:0] S_CU_W    = 5'd15;
  localparam logic [4:0] S_PU0     = 5'd16;
  localparam logic [4:0] S_PU_A    = 5'd17;
  localparam logic [4:0] S_PU_B    = 5'd18;
  localparam logic [4:0] S_PU_L    = 5'd19;
  localparam logic [4:0] S_PU_W    = 5'd20;
  localparam logic [4:0] S_PU_RD   = 5'd21;
  localparam logic [4:0] S_PU_WR   = 5'd22;
  localparam logic [4:0] S_PU_Z    = 5'd23;
  localparam logic [4:0] S_PU_ZW   = 5'd24;
  localparam logic [4:0] S_FIN     = 5'd25;
  localparam logic [4:0] S_EMIT    = 5'd26;
  localparam logic [4:0] S_TRIM    = 5'd27;
  localparam logic [4:0] S_TRIM_CK = 5'd28;
  localparam logic [4:0] S_ZERO    = 5'd29;
  localparam logic [4:0] S_OUT_RD  = 5'd30;
  localparam logic [4:0] S_OUT_LD  = 5'd31;

  localparam logic [5:0] E_LAST = 6'(MOD_BITS - 1);

  logic [4:0]      state_r, state_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   m_r, m_nxt;
  logic [5:0]      e_r, e_nxt;
  logic [ST_W-1:0] err_r, err_nxt;
  logic            last_r, last_nxt;
  logic [CW-1:0]   im1, ip1;
  logic            accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign im1      = i_r - 1'b1;
  assign ip1      = i_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    m_nxt     = m_r;
    e_nxt     = e_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    cmd       = '0;
    raddr     = i_r[AW-1:0];
    waddr     = i_r[AW-1:0];

    unique case (state_r)
      // take a word, decide whether it joins the set
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          last_nxt = in_last_point;
          if (err_r != ST_OK) begin
            if (in_last_point) state_nxt = S_EMIT;
          end else if (k_r == CW'(MAX_POINTS)) begin
            err_nxt = ST_FULL;
            if (in_last_point) state_nxt = S_EMIT;
          end else begin
            cmd.op    = OP_INIT;
            i_nxt     = k_r;
            state_nxt = S_H1;
          end
        end
      end
      // product evaluated at x, highest term first
      S_H1: begin
        if (i_r == '0) begin
          i_nxt     = k_r;
          state_nxt = S_H2;
        end else begin
          i_nxt         = im1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_ACC_A;
          state_nxt     = S_H1_W;
        end
      end
      S_H1_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_ACC_HORNER;
          state_nxt = S_H1;
        end
      end
      // current polynomial evaluated at x
      S_H2: begin
        if (i_r == '0) begin
          state_nxt = S_CHK;
        end else begin
          i_nxt         = im1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_T2_A;
          state_nxt     = S_H2_W;
        end
      end
      S_H2_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_T2_HORNER;
          state_nxt = S_H2;
        end
      end
      // zero product means a repeated x
      S_CHK: begin
        if (sts.acc_zero) begin
          err_nxt   = ST_DUP;
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end else begin
          cmd.op    = OP_INV_INIT;
          e_nxt     = '0;
          state_nxt = S_INV;
        end
      end
      // square and multiply, exponent bits low to high
      S_INV: begin
        if (INV_EXP[e_r]) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_R_B;
          state_nxt     = S_INV_RW;
        end else begin
          state_nxt = S_INV_B;
        end
      end
      S_INV_RW: begin
        if (sts.mul_done) begin
          cmd.op    = OP_R_M;
          state_nxt = S_INV_B;
        end
      end
      S_INV_B: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_B_B;
        state_nxt     = S_INV_BW;
      end
      S_INV_BW: begin
        if (sts.mul_done) begin
          cmd.op = OP_B_M;
          if (e_r == E_LAST) begin
            state_nxt = S_DIFF;
          end else begin
            e_nxt     = e_r + 6'd1;
            state_nxt = S_INV;
          end
        end
      end
      // new newton coefficient
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_T1;
      end
      S_T1: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_R_T2;
        state_nxt     = S_T1_W;
      end
      S_T1_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_ACC_M;
          i_nxt     = '0;
          state_nxt = S_CU;
        end
      end
      // coefficient store update, low to high
      S_CU: begin
        if (i_r == k_r) begin
          cmd.op    = OP_C_ACC;
          waddr     = k_r[AW-1:0];
          state_nxt = S_PU0;
        end else begin
          state_nxt = S_CU_M;
        end
      end
      S_CU_M: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_PD_ACC;
        state_nxt     = S_CU_W;
      end
      S_CU_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_C_UPD;
          i_nxt     = ip1;
          state_nxt = S_CU;
        end
      end
      // product times (X - x), high to low
      S_PU0: begin
        if (last_r) begin
          state_nxt = S_FIN;
        end else if (k_r == '0) begin
          cmd.op    = OP_P_N0;
          waddr     = '0;
          state_nxt = S_FIN;
        end else begin
          i_nxt     = k_r - 1'b1;
          state_nxt = S_PU_A;
        end
      end
      S_PU_A: begin
        state_nxt = S_PU_B;
      end
      S_PU_B: begin
        cmd.op    = OP_P_N;
        waddr     = ip1[AW-1:0];
        state_nxt = S_PU_L;
      end
      S_PU_L: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_PD_N;
        state_nxt     = (i_r == '0) ? S_PU_ZW : S_PU_W;
      end
      S_PU_W: begin
        if (sts.mul_done) begin
          i_nxt     = im1;
          state_nxt = S_PU_RD;
        end
      end
      S_PU_RD: begin
        state_nxt = S_PU_WR;
      end
      S_PU_WR: begin
        cmd.op    = OP_P_MADD;
        waddr     = ip1[AW-1:0];
        state_nxt = S_PU_L;
      end
      S_PU_Z: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_PD_N;
        state_nxt     = S_PU_ZW;
      end
      S_PU_ZW: begin
        if (sts.mul_done) begin
          cmd.op    = OP_P_M;
          waddr     = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        k_nxt     = k_r + 1'b1;
        state_nxt = last_r ? S_EMIT : S_IDLE;
      end
      // error word or start of the trim scan
      S_EMIT: begin
        if (err_r != ST_OK) begin
          if (sts.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_last   = 1'b1;
            cmd.out_status = err_r;
            k_nxt          = '0;
            err_nxt        = ST_OK;
            state_nxt      = S_IDLE;
          end
        end else begin
          i_nxt     = k_r;
          state_nxt = S_TRIM;
        end
      end
      // drop trailing zero coefficients
      S_TRIM: begin
        raddr = im1[AW-1:0];
        state_nxt = (i_r == '0) ? S_ZERO : S_TRIM_CK;
      end
      S_TRIM_CK: begin
        raddr = im1[AW-1:0];
        if (sts.cd_zero) begin
          i_nxt     = im1;
          state_nxt = S_TRIM;
        end else begin
          m_nxt     = i_r;
          i_nxt     = '0;
          state_nxt = S_OUT_RD;
        end
      end
      S_ZERO: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = ST_ZERO;
          k_nxt          = '0;
          state_nxt      = S_IDLE;
        end
      end
      // coefficient words, low degree first
      S_OUT_RD: begin
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (sts.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_use_coef = 1'b1;
          cmd.out_index    = IDX_W'(i_r);
          cmd.out_last     = (ip1 == m_r);
          cmd.out_status   = ST_OK;
          if (ip1 == m_r) begin
            k_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = ip1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      err_r   <= ST_OK;
      i_r     <= '0;
      m_r     <= '0;
      e_r     <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      err_r   <= err_nxt;
      i_r     <= i_nxt;
      m_r     <= m_nxt;
      e_r     <= e_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

/* src/mnint_dp.sv */
// ----------------------------------------------------------------------------
// mnint_dp: interpolation datapath
// Working registers, the product and coefficient stores, the shared
// modular multiplier and the output register.
// ----------------------------------------------------------------------------
module mnint_dp #(
  parameter int MAX_POINTS = mnint_pkg::DEF_MAX_POINTS,
  parameter int AW         = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mnint_pkg::field_t                 in_x_value,
  input  mnint_pkg::field_t                 in_y_value,
  input  mnint_pkg::cmd_t                   cmd,
  input  logic [AW-1:0]                     raddr,
  input  logic [AW-1:0]                     waddr,
  output mnint_pkg::sts_t                   sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mnint_pkg::field_t                 out_coefficient,
  output logic [mnint_pkg::IDX_W-1:0]       out_coefficient_index,
  output logic                              out_last_coefficient,
  output logic [mnint_pkg::ST_W-1:0]        out_status
);
  import mnint_pkg::*;

  field_t          pstore [MAX_POINTS];
  field_t          cstore [MAX_POINTS];

  field_t          a_r, a_nxt, y_r, y_nxt;
  field_t          acc_r, acc_nxt, t2_r, t2_nxt;
  field_t          r_r, r_nxt, b_r, b_nxt;
  field_t          pd_r, cd_r;
  field_t          n;
  field_t          mop_a, mop_b, mres;
  logic            mbusy, mdone;
  logic            pw_en, cw_en;
  field_t          pw_data, cw_data;

  logic            out_valid_r, out_valid_nxt;
  field_t          out_coef_r;
  logic [IDX_W-1:0] out_index_r;
  logic            out_last_r;
  logic [ST_W-1:0] out_status_r;

  assign n = fneg(a_r);

  // multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MS_ACC_A:  begin mop_a = acc_r; mop_b = a_r;   end
      MS_T2_A:   begin mop_a = t2_r;  mop_b = a_r;   end
      MS_R_B:    begin mop_a = r_r;   mop_b = b_r;   end
      MS_B_B:    begin mop_a = b_r;   mop_b = b_r;   end
      MS_R_T2:   begin mop_a = r_r;   mop_b = t2_r;  end
      MS_PD_ACC: begin mop_a = pd_r;  mop_b = acc_r; end
      MS_PD_N:   begin mop_a = pd_r;  mop_b = n;     end
      default:   begin mop_a = acc_r; mop_b = a_r;   end
    endcase
  end

  mnint_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .op_a  (mop_a),
    .op_b  (mop_b),
    .busy  (mbusy),
    .done  (mdone),
    .res   (mres)
  );

  // register and store updates
  always_comb begin
    a_nxt   = a_r;
    y_nxt   = y_r;
    acc_nxt = acc_r;
    t2_nxt  = t2_r;
    r_nxt   = r_r;
    b_nxt   = b_r;
    pw_en   = 1'b0;
    cw_en   = 1'b0;
    pw_data = mres;
    cw_data = acc_r;
    if (cmd.load) begin
      a_nxt = in_fold(in_x_value);
      y_nxt = in_fold(in_y_value);
    end
    unique case (cmd.op)
      OP_NONE: ;
      OP_INIT: begin
        acc_nxt = field_t'(1);
        t2_nxt  = '0;
      end
      OP_ACC_HORNER: acc_nxt = fadd(mres, pd_r);
      OP_T2_HORNER:  t2_nxt  = fadd(mres, cd_r);
      OP_INV_INIT: begin
        r_nxt = field_t'(1);
        b_nxt = acc_r;
      end
      OP_R_M:   r_nxt   = mres;
      OP_B_M:   b_nxt   = mres;
      OP_DIFF:  t2_nxt  = fsub(y_r, t2_r);
      OP_ACC_M: acc_nxt = mres;
      OP_C_UPD: begin
        cw_en   = 1'b1;
        cw_data = fadd(cd_r, mres);
      end
      OP_C_ACC: cw_en = 1'b1;
      OP_P_N0: begin
        pw_en   = 1'b1;
        pw_data = n;
      end
      OP_P_N: begin
        pw_en   = 1'b1;
        pw_data = fadd(n, pd_r);
      end
      OP_P_MADD: begin
        pw_en   = 1'b1;
        pw_data = fadd(mres, pd_r);
      end
      OP_P_M: pw_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    t2_r  <= t2_nxt;
    r_r   <= r_nxt;
    b_r   <= b_nxt;
  end

  // stores, registered read
  always_ff @(posedge clk) begin
    if (pw_en) pstore[waddr] <= pw_data;
    pd_r <= pstore[raddr];
  end

  always_ff @(posedge clk) begin
    if (cw_en) cstore[waddr] <= cw_data;
    cd_r <= cstore[raddr];
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_coef_r   <= cmd.out_use_coef ? cd_r : '0;
      out_index_r  <= cmd.out_index;
      out_last_r   <= cmd.out_last;
      out_status_r <= cmd.out_status;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_coefficient       = out_coef_r;
  assign out_coefficient_index = out_index_r;
  assign out_last_coefficient  = out_last_r;
  assign out_status            = out_status_r;

  // status to the sequencer
  assign sts.mul_busy = mbusy;
  assign sts.mul_done = mdone;
  assign sts.acc_zero = (acc_r == '0);
  assign sts.cd_zero  = (cd_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

/* src/mersenne_newton_interpolator.sv */
// ----------------------------------------------------------------------------
// mersenne_newton_interpolator: Newton interpolation over GF(2^61-1)
// One word at a time; every modular multiply runs on the single shared
// multiplier, and a point holds the input through Horner twice, the
// inverse of 121 multiplies and two updates; the last point skips the
// product update, then scans the coefficients from the top and emits
// the words.
// Reset clears count and error; stores need no clearing.
// ----------------------------------------------------------------------------
module mersenne_newton_interpolator #(
  parameter int MAX_POINTS = mnint_pkg::DEF_MAX_POINTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mnint_pkg::field_t           in_x_value,
  input  mnint_pkg::field_t           in_y_value,
  input  logic                        in_last_point,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mnint_pkg::field_t           out_coefficient,
  output logic [mnint_pkg::IDX_W-1:0] out_coefficient_index,
  output logic                        out_last_coefficient,
  output logic [mnint_pkg::ST_W-1:0]  out_status
);
  import mnint_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] raddr, waddr;

  mnint_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .CW         (CW),
    .AW         (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_last_point (in_last_point),
    .sts           (sts),
    .cmd           (cmd),
    .raddr         (raddr),
    .waddr         (waddr)
  );

  mnint_dp #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_x_value            (in_x_value),
    .in_y_value            (in_y_value),
    .cmd                   (cmd),
    .raddr                 (raddr),
    .waddr                 (waddr),
    .sts                   (sts),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_coefficient       (out_coefficient),
    .out_coefficient_index (out_coefficient_index),
    .out_last_coefficient  (out_last_coefficient),
    .out_status            (out_status)
  );

`ifndef ASSERT_OFF
  // a pending word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free) else $error("output word overwritten");

  // multiplier is started only when idle
  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !sts.mul_busy) else $error("multiplier restarted while busy");

  // status words are single, zero and last
  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_last_coefficient && out_coefficient == '0 && out_coefficient_index == '0))
    else $error("malformed status word");

  // trimmed top coefficient is nonzero
  a_trim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK && out_last_coefficient) |->
      (out_coefficient != '0)) else $error("trailing zero emitted");
`endif

endmodule
